// ===== src/kplrd_pkg.sv =====
// Shared types and constants for the key press / long press / repeat detector.
// Holds event codes, register indexes and reset values; no dependencies.
package kplrd_pkg;

    localparam int unsigned NUM_KEYS_DEF = 4;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned PIN_W    = 4;
    localparam int unsigned KIDX_W   = 2;
    localparam int unsigned EVENT_W  = 3;
    localparam int unsigned CIDX_W   = 2;

    typedef logic [EVENT_W-1:0] event_t;
    typedef logic [CIDX_W-1:0]  cfg_idx_t;

    localparam event_t EV_NONE    = 3'd0;
    localparam event_t EV_PRESS   = 3'd1;
    localparam event_t EV_LONG    = 3'd2;
    localparam event_t EV_REPEAT  = 3'd3;
    localparam event_t EV_RELEASE = 3'd4;

    localparam cfg_idx_t REG_LONG_PRESS = 2'd0;
    localparam cfg_idx_t REG_REPEAT     = 2'd1;
    localparam cfg_idx_t REG_ACTIVE_HI  = 2'd2;

    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1500;
    localparam logic [CFG_W-1:0] REPEAT_RST     = 16'd100;
    localparam logic [PIN_W-1:0] ACTIVE_HI_RST  = 4'd0;

endpackage

// ===== src/key_press_longpress_repeat_detector_unit.sv =====
// Key press / long press / auto-repeat detector, top level.
// Depends on kplrd_pkg for event codes, register indexes and reset values.
// After a scan is taken, each key passes in turn through the hold compare, repeat
// compare and output steps; the output step holds while out_ready is low.
// A new scan is taken only once the last key's event has transferred. The one shared
// 32-bit subtract-and-compare unit is used twice per key. Reset (rst_n low, asynchronous)
// clears all key state and loads the register defaults 1500, 100 and 0.
module key_press_longpress_repeat_detector_unit
#(
    parameter int unsigned NUM_KEYS = kplrd_pkg::NUM_KEYS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [kplrd_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [kplrd_pkg::CFG_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [kplrd_pkg::PIN_W-1:0]    pin_levels,
    input  logic [kplrd_pkg::TIME_W-1:0]   now_ms,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [kplrd_pkg::KIDX_W-1:0]   key_index,
    output logic [kplrd_pkg::EVENT_W-1:0]  event_res,
    output logic                           last_key
);
    import kplrd_pkg::*;

    localparam int unsigned KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [KEY_W-1:0] LAST_KEY_IDX = KEY_W'(NUM_KEYS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HOLD = 2'd1;
    localparam logic [1:0] ST_REP  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [KEY_W-1:0]  key_cnt_reg, key_cnt_next;
    logic [CFG_W-1:0]  long_press_reg;
    logic [CFG_W-1:0]  repeat_reg;
    logic [PIN_W-1:0]  active_hi_reg;
    logic [PIN_W-1:0]  pins_reg;
    logic [TIME_W-1:0] now_reg;
    logic              hold_gt_reg;
    event_t            event_reg, event_next;

    logic              was_pressed_reg [NUM_KEYS];
    logic              long_active_reg [NUM_KEYS];
    logic [TIME_W-1:0] start_reg       [NUM_KEYS];
    logic [TIME_W-1:0] last_rep_reg    [NUM_KEYS];

    logic [TIME_W-1:0] sub_b;
    logic [TIME_W-1:0] diff;
    logic [CFG_W-1:0]  limit;
    logic              cmp_gt;
    logic              lvl;
    logic              act;
    logic              pressed;
    logic              in_xfer;
    logic              out_xfer;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;
    assign key_index = KIDX_W'(key_cnt_reg);
    assign event_res = event_reg;
    assign last_key  = (key_cnt_reg == LAST_KEY_IDX);

    // Keys above the pin field read level 0 and an active-low setting
    assign lvl     = |((pins_reg >> key_cnt_reg) & PIN_W'(1));
    assign act     = |((active_hi_reg >> key_cnt_reg) & PIN_W'(1));
    assign pressed = (lvl == act);

    // Shared unit: modulo-2^32 elapsed time compared against an interval
    always_comb
    begin
        if (state_reg == ST_REP)
        begin
            sub_b = last_rep_reg[key_cnt_reg];
            limit = repeat_reg;
        end
        else
        begin
            sub_b = start_reg[key_cnt_reg];
            limit = long_press_reg;
        end
        diff   = now_reg - sub_b;
        cmp_gt = (diff > {{(TIME_W-CFG_W){1'b0}}, limit});
    end

    // Decide the key's event from its flags and both compare results
    always_comb
    begin
        event_next = EV_NONE;
        if (pressed)
        begin
            if (was_pressed_reg[key_cnt_reg])
            begin
                if (hold_gt_reg)
                begin
                    if (!long_active_reg[key_cnt_reg])
                        event_next = EV_LONG;
                    else if (cmp_gt)
                        event_next = EV_REPEAT;
                end
            end
            else
            begin
                event_next = EV_PRESS;
            end
        end
        else if (was_pressed_reg[key_cnt_reg])
        begin
            event_next = EV_RELEASE;
        end
    end

    // Sequence: hold compare, repeat compare, output transfer, per key
    always_comb
    begin
        state_next   = state_reg;
        key_cnt_next = key_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next   = ST_HOLD;
                    key_cnt_next = '0;
                end
            end
            ST_HOLD:
                state_next = ST_REP;
            ST_REP:
                state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (key_cnt_reg == LAST_KEY_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next   = ST_HOLD;
                        key_cnt_next = key_cnt_reg + KEY_W'(1);
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            key_cnt_reg    <= '0;
            long_press_reg <= LONG_PRESS_RST;
            repeat_reg     <= REPEAT_RST;
            active_hi_reg  <= ACTIVE_HI_RST;
        end
        else
        begin
            state_reg   <= state_next;
            key_cnt_reg <= key_cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LONG_PRESS: long_press_reg <= cfg_data;
                    REG_REPEAT:     repeat_reg     <= cfg_data;
                    REG_ACTIVE_HI:  active_hi_reg  <= cfg_data[PIN_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // Capture the scan, the hold compare and the event
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pins_reg <= pin_levels;
            now_reg  <= now_ms;
        end
        if (state_reg == ST_HOLD)
            hold_gt_reg <= cmp_gt;
        if (state_reg == ST_REP)
            event_reg <= event_next;
    end

    // Per-key state, updated once per key in the repeat-compare step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                was_pressed_reg[i] <= 1'b0;
                long_active_reg[i] <= 1'b0;
                start_reg[i]       <= '0;
                last_rep_reg[i]    <= '0;
            end
        end
        else if (state_reg == ST_REP)
        begin
            if (pressed)
            begin
                was_pressed_reg[key_cnt_reg] <= 1'b1;
                if (event_next == EV_PRESS)
                    start_reg[key_cnt_reg] <= now_reg;
                if (event_next == EV_LONG)
                    long_active_reg[key_cnt_reg] <= 1'b1;
                if ((event_next == EV_LONG) || (event_next == EV_REPEAT))
                    last_rep_reg[key_cnt_reg] <= now_reg;
            end
            else
            begin
                was_pressed_reg[key_cnt_reg] <= 1'b0;
                long_active_reg[key_cnt_reg] <= 1'b0;
                start_reg[key_cnt_reg]       <= '0;
                last_rep_reg[key_cnt_reg]    <= '0;
            end
        end
    end

    // A scan transfer starts at the first key
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_HOLD) && (key_cnt_reg == '0))
        else $error("scan did not start at key zero");

    // The final key's transfer frees the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && last_key) |=> in_ready)
        else $error("block not ready after last event of a scan");

    // A long press event leaves the key marked long-active
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_res == EV_LONG)) |-> long_active_reg[key_cnt_reg])
        else $error("long press without long-active flag");

    // A release event leaves the key not pressed
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_res == EV_RELEASE)) |-> !was_pressed_reg[key_cnt_reg])
        else $error("release with key still marked pressed");

endmodule
